@@ hdl/arpc_pkg.sv @@
// Package for the ARP cache resolver: item and result beats, queue entries,
// command classes, entry status codes and back-end states. No dependencies.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int DefaultCacheEntries = 16;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_PACKET  = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Opcodes in a sent frame.
  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_REPLY   = 2'd2;

  // Header values a received packet must carry.
  localparam logic [15:0] MIN_PAYLOAD   = 16'd28;
  localparam logic [15:0] HW_ETHERNET   = 16'd1;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IP  = 8'd4;
  localparam logic [15:0] ARP_OP_REQ    = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] TIME_MAX      = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] REG_LIFETIME  = 2'd2;
  localparam logic [1:0] REG_RETRY     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] now_ms;
    logic [31:0] query_ip;
    logic [15:0] payload_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arpc_in_t;

  typedef struct packed {
    logic        found;
    logic [47:0] resolved_mac;
    logic        send_frame;
    logic [1:0]  send_opcode;
    logic [47:0] send_dest_mac;
    logic [47:0] send_target_mac;
    logic [31:0] send_target_ip;
  } arpc_out_t;

  // What the back end must do with a queued beat.
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_LOOKUP,
    KIND_RESOLVE,
    KIND_LEARN,
    KIND_PACKET
  } arpc_kind_t;

  typedef struct packed {
    arpc_kind_t  kind;
    logic        reply;
    logic [47:0] now_ms;
    logic [31:0] key_ip;
    logic [47:0] sender_mac;
  } arpc_job_t;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_PENDING,
    ST_RESOLVED
  } arpc_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } arpc_bk_state_t;

endpackage

@@ hdl/arpc_front.sv @@
// Front end of the ARP cache resolver: accepts command beats, classifies them
// and holds them in a two-entry queue. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_front import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  arpc_in_t    item,
  input  logic [31:0] local_ip,
  output logic        job_valid,
  output arpc_job_t   job,
  input  logic        job_take
);

  arpc_job_t  queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       pkt_ok;
  arpc_job_t  cls;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign pop       = job_take && job_valid;
  assign job       = queue[rd_ptr];

  // Classify the beat and check the packet header.
  always_comb begin
    pkt_ok = (item.payload_length >= MIN_PAYLOAD) && (item.hw_type == HW_ETHERNET) &&
             (item.proto_type == PROTO_IPV4) && (item.hw_addr_len == HW_LEN_ETH) &&
             (item.proto_addr_len == PROTO_LEN_IP);
    cls.now_ms     = item.now_ms;
    cls.sender_mac = item.sender_mac;
    cls.key_ip     = (item.command == CMD_PACKET) ? item.sender_ip : item.query_ip;
    cls.reply      = (item.command == CMD_PACKET) && pkt_ok &&
                     (item.opcode == ARP_OP_REQ) && (item.target_ip == local_ip);
    case (item.command)
      CMD_LOOKUP:  cls.kind = KIND_LOOKUP;
      CMD_RESOLVE: cls.kind = KIND_RESOLVE;
      CMD_PACKET: begin
        if (!pkt_ok) cls.kind = KIND_NOP;
        else if (item.sender_ip != 32'd0) cls.kind = KIND_LEARN;
        else cls.kind = KIND_PACKET;
      end
      default:     cls.kind = KIND_NOP;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cls;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/arpc_back.sv @@
// Back end of the ARP cache resolver: owns the entry table, scans it one
// entry per cycle, applies the update and registers the result beat.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_back import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = DefaultCacheEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  arpc_job_t   job,
  output logic        job_take,
  input  logic [31:0] entry_lifetime_ms,
  input  logic [15:0] retry_interval_ms,
  output logic        done,
  output arpc_out_t   result
);

  localparam int IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);

  arpc_status_t   entry_status [CACHE_ENTRIES];
  logic [31:0]    entry_ip     [CACHE_ENTRIES];
  logic [47:0]    entry_mac    [CACHE_ENTRIES];
  logic [47:0]    entry_expiry [CACHE_ENTRIES];

  arpc_bk_state_t state, state_next;
  arpc_job_t      cur;
  logic [IdxW-1:0] cnt;

  // Scan findings.
  logic            hit;
  logic [IdxW-1:0] hidx;
  arpc_status_t    hstat;
  logic [47:0]     hmac;
  logic [47:0]     hexp;
  logic            have_empty;
  logic [IdxW-1:0] eidx;
  logic [IdxW-1:0] vidx;
  arpc_status_t    vstat;
  logic [47:0]     vexp;

  // Finish-step decisions.
  logic            live;
  logic            expired;
  logic [IdxW-1:0] slot;
  arpc_status_t    slot_stat;
  logic [47:0]     slot_exp;
  logic [48:0]     retry_sum;
  logic [48:0]     life_sum;
  logic [47:0]     retry_time;
  logic [47:0]     life_time;
  logic            stat_we;
  logic [IdxW-1:0] stat_idx;
  arpc_status_t    stat_val;
  logic            data_we;
  logic            mac_we;
  logic [47:0]     exp_val;
  arpc_out_t       res;

  assign job_take = (state == BK_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (job_valid) state_next = BK_SCAN;
      BK_SCAN:   if (cnt == LastIdx) state_next = BK_FINISH;
      BK_FINISH: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Job capture and table scan, one entry per cycle.
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && job_valid) begin
      cur        <= job;
      cnt        <= '0;
      hit        <= 1'b0;
      have_empty <= 1'b0;
    end else if (state == BK_SCAN) begin
      cnt <= cnt + 1'b1;
      if (!hit && entry_status[cnt] != ST_EMPTY && entry_ip[cnt] == cur.key_ip) begin
        hit   <= 1'b1;
        hidx  <= cnt;
        hstat <= entry_status[cnt];
        hmac  <= entry_mac[cnt];
        hexp  <= entry_expiry[cnt];
      end
      if (!have_empty && entry_status[cnt] == ST_EMPTY) begin
        have_empty <= 1'b1;
        eidx       <= cnt;
      end
      if (cnt == '0 || entry_expiry[cnt] < vexp) begin
        vidx  <= cnt;
        vexp  <= entry_expiry[cnt];
        vstat <= entry_status[cnt];
      end
    end
  end

  // Decide the update and the result once the scan is through.
  always_comb begin
    live      = hit && (hstat == ST_RESOLVED) && (cur.now_ms < hexp);
    expired   = hit && (hstat == ST_RESOLVED) && !(cur.now_ms < hexp);
    slot      = hit ? hidx : (have_empty ? eidx : vidx);
    slot_stat = hit ? (expired ? ST_EMPTY : hstat) : (have_empty ? ST_EMPTY : vstat);
    slot_exp  = hit ? hexp : vexp;
    retry_sum = {1'b0, cur.now_ms} + {33'd0, retry_interval_ms};
    life_sum  = {1'b0, cur.now_ms} + {17'd0, entry_lifetime_ms};
    retry_time = retry_sum[48] ? TIME_MAX : retry_sum[47:0];
    life_time  = life_sum[48] ? TIME_MAX : life_sum[47:0];
    stat_we  = 1'b0;
    stat_idx = slot;
    stat_val = ST_EMPTY;
    data_we  = 1'b0;
    mac_we   = 1'b0;
    exp_val  = retry_time;
    res      = '0;
    case (cur.kind)
      KIND_LOOKUP: begin
        if (live) begin
          res.found        = 1'b1;
          res.resolved_mac = hmac;
        end else if (expired) begin
          stat_we  = 1'b1;
          stat_idx = hidx;
        end
      end
      KIND_RESOLVE: begin
        if (live) begin
          res.found        = 1'b1;
          res.resolved_mac = hmac;
        end else if (slot_stat != ST_PENDING || !(cur.now_ms < slot_exp)) begin
          stat_we             = 1'b1;
          stat_val            = ST_PENDING;
          data_we             = 1'b1;
          res.send_frame      = 1'b1;
          res.send_opcode     = SEND_REQUEST;
          res.send_dest_mac   = MAC_BROADCAST;
          res.send_target_ip  = cur.key_ip;
        end
      end
      KIND_LEARN: begin
        stat_we  = 1'b1;
        stat_val = ST_RESOLVED;
        data_we  = 1'b1;
        mac_we   = 1'b1;
        exp_val  = life_time;
      end
      default: ;
    endcase
    // A request aimed at this station is answered to its sender.
    if (cur.reply) begin
      res.send_frame      = 1'b1;
      res.send_opcode     = SEND_REPLY;
      res.send_dest_mac   = cur.sender_mac;
      res.send_target_mac = cur.sender_mac;
      res.send_target_ip  = cur.key_ip;
    end
  end

  // Entry status, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) entry_status[i] <= ST_EMPTY;
    end else if (state == BK_FINISH && stat_we) begin
      entry_status[stat_idx] <= stat_val;
    end
  end

  // Entry payload, valid only once written.
  always_ff @(posedge clk) begin
    if (state == BK_FINISH && data_we) begin
      entry_ip[slot]     <= cur.key_ip;
      entry_expiry[slot] <= exp_val;
      if (mac_we) entry_mac[slot] <= cur.sender_mac;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == BK_FINISH);
  end

  always_ff @(posedge clk) begin
    if (state == BK_FINISH) result <= res;
  end

endmodule

@@ hdl/arp_cache_resolver.sv @@
// Top level of the ARP cache resolver: configuration registers, front end
// with its queue, and back end with the entry table. Depends on arpc_pkg,
// arpc_front and arpc_back.
`timescale 1ns / 1ps

// Usage:
// A command beat (lookup, resolve or received ARP packet) is taken at a
// clock edge where start is high and busy is low. The front end queues up
// to two beats; busy rises only when that queue is full.
// Each beat gives exactly one result beat, shown on result for one cycle
// with done high. The receiver cannot stall; results must be taken then.
// The back end scans the table one entry per cycle and works on one beat at a
// time: it takes the next queued beat only after it has registered the
// previous beat's result and returned to idle, so the throughput is set by
// the scan loop over the table.
// Configuration is written through cfg_we, cfg_index and cfg_data with the
// block idle: index 0 local IP, 1 local MAC, 2 entry lifetime in ms,
// 3 retry interval in ms.
// Reset empties every table entry at once, drops queued beats and restores
// the register defaults (lifetime 60000 ms, retry 1000 ms).
module arp_cache_resolver import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = DefaultCacheEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  arpc_in_t    item,
  output logic        done,
  output arpc_out_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [31:0] local_ip;
  logic [31:0] entry_lifetime_ms;
  logic [15:0] retry_interval_ms;
  logic        job_valid;
  logic        job_take;
  arpc_job_t   job;

  // Configuration registers. The local MAC is accepted but not kept: it would
  // only feed the sender field of a sent frame, which is built outside.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip          <= 32'd0;
      entry_lifetime_ms <= 32'd60000;
      retry_interval_ms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_IP:  local_ip <= cfg_data[31:0];
        REG_LOCAL_MAC: ;
        REG_LIFETIME:  entry_lifetime_ms <= cfg_data[31:0];
        REG_RETRY:     retry_interval_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .local_ip  (local_ip),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  arpc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (job_valid),
    .job               (job),
    .job_take          (job_take),
    .entry_lifetime_ms (entry_lifetime_ms),
    .retry_interval_ms (retry_interval_ms),
    .done              (done),
    .result            (result)
  );

endmodule

@@ tb/sv/arpc_checker.sv @@
// Checker for the ARP cache resolver: watches the command, configuration and
// result channels, predicts each result beat from its own copy of the table
// and compares it field by field. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_checker import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = DefaultCacheEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  arpc_in_t    item,
  input  logic        done,
  input  arpc_out_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Predicted register copies.
  logic [31:0] my_ip;
  logic [31:0] lifetime_ms;
  logic [15:0] retry_ms;

  // Predicted table.
  arpc_status_t slot_status [CACHE_ENTRIES];
  logic [31:0]  slot_ip     [CACHE_ENTRIES];
  logic [47:0]  slot_mac    [CACHE_ENTRIES];
  logic [47:0]  slot_expiry [CACHE_ENTRIES];

  arpc_out_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [47:0] expiry_after(logic [47:0] now, logic [31:0] span);
    logic [48:0] sum;
    sum = {1'b0, now} + {17'd0, span};
    return sum[48] ? TIME_MAX : sum[47:0];
  endfunction

  // First non-empty entry holding ip; a resolved entry past its expiry is dropped
  // but its slot is still returned.
  function automatic int find_entry(logic [31:0] ip, logic [47:0] now);
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (slot_status[i] != ST_EMPTY && slot_ip[i] == ip) begin
        if (slot_status[i] == ST_RESOLVED && now >= slot_expiry[i])
          slot_status[i] = ST_EMPTY;
        return i;
      end
    end
    return -1;
  endfunction

  // First empty slot, else the one that expires earliest.
  function automatic int pick_slot();
    int victim;
    victim = 0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (slot_status[i] == ST_EMPTY) return i;
      if (slot_expiry[i] < slot_expiry[victim]) victim = i;
    end
    return victim;
  endfunction

  function automatic arpc_out_t resolve_beat(arpc_in_t b);
    arpc_out_t r;
    int e;
    r = '0;
    if (b.command == CMD_LOOKUP || b.command == CMD_RESOLVE) begin
      e = find_entry(b.query_ip, b.now_ms);
      if (e >= 0 && slot_status[e] == ST_RESOLVED) begin
        r.found = 1'b1;
        r.resolved_mac = slot_mac[e];
      end else if (b.command == CMD_RESOLVE) begin
        if (e < 0) e = pick_slot();
        if (slot_status[e] != ST_PENDING || b.now_ms >= slot_expiry[e]) begin
          slot_ip[e] = b.query_ip;
          slot_status[e] = ST_PENDING;
          slot_expiry[e] = expiry_after(b.now_ms, {16'd0, retry_ms});
          r.send_frame = 1'b1;
          r.send_opcode = SEND_REQUEST;
          r.send_dest_mac = MAC_BROADCAST;
          r.send_target_ip = b.query_ip;
        end
      end
    end else if (b.command == CMD_PACKET) begin
      if (b.payload_length >= MIN_PAYLOAD && b.hw_type == HW_ETHERNET &&
          b.proto_type == PROTO_IPV4 && b.hw_addr_len == HW_LEN_ETH &&
          b.proto_addr_len == PROTO_LEN_IP) begin
        if (b.sender_ip != '0) begin
          e = find_entry(b.sender_ip, b.now_ms);
          if (e < 0) e = pick_slot();
          slot_ip[e] = b.sender_ip;
          slot_mac[e] = b.sender_mac;
          slot_status[e] = ST_RESOLVED;
          slot_expiry[e] = expiry_after(b.now_ms, lifetime_ms);
        end
        if (b.opcode == ARP_OP_REQ && b.target_ip == my_ip) begin
          r.send_frame = 1'b1;
          r.send_opcode = SEND_REPLY;
          r.send_dest_mac = b.sender_mac;
          r.send_target_mac = b.sender_mac;
          r.send_target_ip = b.sender_ip;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      my_ip <= '0;
      lifetime_ms <= 32'd60000;
      retry_ms <= 16'd1000;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        slot_status[i] = ST_EMPTY;
        slot_expiry[i] = '0;
      end
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // Result beat against the oldest prediction.
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          arpc_out_t want;
          want = expected_results.pop_front();
          check_field("found", 48'(want.found), 48'(result.found));
          check_field("resolved_mac", want.resolved_mac, result.resolved_mac);
          check_field("send_frame", 48'(want.send_frame), 48'(result.send_frame));
          check_field("send_opcode", 48'(want.send_opcode), 48'(result.send_opcode));
          check_field("send_dest_mac", want.send_dest_mac, result.send_dest_mac);
          check_field("send_target_mac", want.send_target_mac, result.send_target_mac);
          check_field("send_target_ip", 48'(want.send_target_ip),
                      48'(result.send_target_ip));
        end
      end
      if (start && !busy) expected_results.push_back(resolve_beat(item));
      if (cfg_we) begin
        case (cfg_index)
          REG_LOCAL_IP:  my_ip <= cfg_data[31:0];
          REG_LOCAL_MAC: ;
          REG_LIFETIME:  lifetime_ms <= cfg_data[31:0];
          REG_RETRY:     retry_ms <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the ARP cache resolver testbench: clock, reset, command stimulus
// and configuration phases, and the verdict. Depends on arpc_pkg,
// arpc_checker and arp_cache_resolver.
`timescale 1ns / 1ps

module testbench;
  import arpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  arpc_in_t    item = '0;
  logic        done;
  arpc_out_t   result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  logic [31:0] ip_pool [24];
  logic [31:0] station_ip;
  logic [47:0] clock_ms;
  logic [31:0] time_step_max;

  always #1 clk = ~clk;

  arp_cache_resolver dut (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_we, .cfg_index, .cfg_data
  );

  arpc_checker u_checker (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    #2ms;
    $display("[arp_cache_resolver] ERROR");
    $finish;
  end

  // Drive one command beat and hold it until it is taken.
  task automatic send_beat(arpc_in_t b);
    start <= 1'b1;
    item <= b;
    do @(posedge clk); while (busy);
  endtask

  // Idle gap after a beat: mostly none or short, sometimes long.
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 99) < 40) ? 0 :
        ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] ip, logic [47:0] mac, logic [31:0] life,
                            logic [15:0] retry);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOCAL_IP;  cfg_data <= {16'd0, ip};    @(posedge clk);
    cfg_index <= REG_LOCAL_MAC; cfg_data <= mac;            @(posedge clk);
    cfg_index <= REG_LIFETIME;  cfg_data <= {16'd0, life};  @(posedge clk);
    cfg_index <= REG_RETRY;     cfg_data <= {32'd0, retry}; @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    station_ip = ip;
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()} & TIME_MAX;
  endfunction

  function automatic arpc_in_t query_beat(logic [1:0] cmd, logic [31:0] ip,
                                          logic [47:0] now);
    arpc_in_t b;
    b = '0;
    b.command = cmd;
    b.query_ip = ip;
    b.now_ms = now;
    return b;
  endfunction

  function automatic arpc_in_t packet_beat(logic [15:0] op, logic [47:0] mac,
                                           logic [31:0] sip, logic [31:0] tip,
                                           logic [47:0] now);
    arpc_in_t b;
    b = '0;
    b.command = CMD_PACKET;
    b.now_ms = now;
    b.payload_length = MIN_PAYLOAD + 16'($urandom_range(0, 3));
    b.hw_type = HW_ETHERNET;
    b.proto_type = PROTO_IPV4;
    b.hw_addr_len = HW_LEN_ETH;
    b.proto_addr_len = PROTO_LEN_IP;
    b.opcode = op;
    b.sender_mac = mac;
    b.sender_ip = sip;
    b.target_ip = tip;
    return b;
  endfunction

  function automatic arpc_in_t random_beat();
    arpc_in_t b;
    logic [31:0] ip;
    logic [319:0] raw;
    int pick;
    pick = $urandom_range(0, 99);
    ip = ip_pool[$urandom_range(0, 23)];
    clock_ms = clock_ms + (($urandom_range(0, 49) == 0) ?
               48'(time_step_max) * 8 : 48'($urandom_range(0, time_step_max)));
    if (pick < 33) begin
      b = query_beat(CMD_LOOKUP, ip, clock_ms);
    end else if (pick < 63) begin
      b = query_beat(CMD_RESOLVE, ip, clock_ms);
    end else if (pick < 92) begin
      b = packet_beat(($urandom_range(0, 9) < 5) ? ARP_OP_REQ :
                      ($urandom_range(0, 9) < 8) ? ARP_OP_REPLY : 16'($urandom()),
                      rand48(), ($urandom_range(0, 19) == 0) ? 32'd0 : ip,
                      ($urandom_range(0, 1) == 1) ? station_ip : ip_pool[0], clock_ms);
      // Broken packet: one header field spoiled.
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: b.payload_length = 16'($urandom_range(0, 27));
          1: b.hw_type = 16'($urandom());
          2: b.proto_type = 16'($urandom());
          3: b.hw_addr_len = 8'($urandom());
          default: b.proto_addr_len = 8'($urandom());
        endcase
      end
    end else begin
      // Noise: every field random, including the unused command.
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
      b = raw[$bits(arpc_in_t)-1:0];
    end
    return b;
  endfunction

  initial begin
    logic [31:0] q_ip;
    arpc_in_t b;
    for (int i = 0; i < 24; i++) ip_pool[i] = $urandom() | 32'd1;
    station_ip = '0;
    clock_ms = 48'd1000;
    time_step_max = 400;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats with the reset register values.
    q_ip = ip_pool[1];
    send_beat(query_beat(CMD_LOOKUP, q_ip, 48'd100));
    send_beat(query_beat(CMD_RESOLVE, q_ip, 48'd100));
    send_beat(query_beat(CMD_RESOLVE, q_ip, 48'd500));    // pending, no resend yet
    send_beat(query_beat(CMD_RESOLVE, q_ip, 48'd1100));   // retry time reached
    send_beat(packet_beat(ARP_OP_REPLY, 48'h0000_1234_5678, q_ip, 32'd9, 48'd1200));
    send_beat(query_beat(CMD_LOOKUP, q_ip, 48'd1300));
    send_beat(query_beat(CMD_RESOLVE, q_ip, 48'd1300));
    send_beat(query_beat(CMD_LOOKUP, q_ip, 48'd61200));   // expired
    send_beat(packet_beat(ARP_OP_REQ, TIME_MAX, ip_pool[2], 32'd0, 48'd61300));
    send_beat(packet_beat(ARP_OP_REQ, 48'h0000_0000_0001, 32'd0, 32'd0, 48'd61300));
    send_beat(packet_beat(16'hFFFF, 48'hABCD_0000_0001, ip_pool[3], 32'd0, TIME_MAX - 5));
    send_beat(query_beat(CMD_LOOKUP, ip_pool[3], TIME_MAX - 1));
    send_beat(query_beat(CMD_RESOLVE, 32'hFFFF_FFFF, TIME_MAX));
    send_beat(query_beat(CMD_RESOLVE, 32'd0, 48'd0));
    b = query_beat(CMD_UNUSED, q_ip, 48'd5);
    send_beat(b);
    b = packet_beat(ARP_OP_REQ, 48'h1, ip_pool[4], 32'd0, 48'd70000);
    b.payload_length = 16'd27;
    send_beat(b);
    b.payload_length = 16'hFFFF; b.hw_type = 16'd2;          send_beat(b);
    b.hw_type = HW_ETHERNET;     b.proto_type = 16'h86DD;    send_beat(b);
    b.proto_type = PROTO_IPV4;   b.hw_addr_len = 8'hFF;      send_beat(b);
    b.hw_addr_len = HW_LEN_ETH;  b.proto_addr_len = 8'd0;    send_beat(b);
    b.proto_addr_len = PROTO_LEN_IP;                         send_beat(b);
    send_beat(query_beat(CMD_LOOKUP, ip_pool[4], 48'd70001));
    drain();

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_regs(32'hFFFF_FFFF, TIME_MAX, 32'd1, 16'd1);
          time_step_max = 3;
        end
        2: begin
          write_regs(32'd0, 48'd0, 32'hFFFF_FFFF, 16'hFFFF);
          time_step_max = 100000;
        end
        3: begin
          write_regs(ip_pool[0], rand48(), $urandom_range(50, 3000),
                     16'($urandom_range(10, 500)));
          time_step_max = 300;
        end
        default: begin
          write_regs(ip_pool[5], rand48(), 32'd200, 16'd100);
          time_step_max = 60;
        end
      endcase
      clock_ms = 48'($urandom_range(0, 1000));
      for (int n = 0; n < 280; n++) begin
        send_beat(random_beat());
        sender_gap();
      end
      drain();
    end

    if (fail_count == 0)
      $display("[arp_cache_resolver] OK");
    else
      $display("[arp_cache_resolver] ERROR");
    $finish;
  end

endmodule
